[rtl/gtf_pkg.sv]
// Shared types, constants and arithmetic helpers of the GTF timing generator.
package gtf_pkg;

    // Fixed point and formula constants
    localparam int FRAC_BITS   = 32;
    localparam int MIN_VBP_US  = 550;
    localparam int US_PER_S    = 1000000;
    localparam logic [13:0] MAX14 = 14'h3FFF;
    localparam logic [25:0] MAX26 = 26'h3FF_FFFF;

    // Reciprocal of 100 for the hsync rounding: floor(x * RCP100 >> RCP100_SH)
    localparam int RCP100     = 41944;
    localparam int RCP100_SH  = 22;

    // Pixel clock divide by 10^6 = 64 * 15625:
    // floor(y / 15625) = floor(y * RCP15625 >> RCP15625_SH) for y < 2^36
    localparam logic [35:0] RCP15625    = 36'd36028797019;
    localparam int          RCP15625_SH = 49;
    localparam int          CLK_PRE_SH  = 6;

    // Quotient widths of the three long divisions
    localparam int D1_QW = 52;   // line period estimate
    localparam int D2_QW = 15;   // vsync plus back porch lines
    localparam int D3_QW = 11;   // blanking cells

    // Pipeline stage map
    localparam int ST_IN     = 0;
    localparam int D1_FIRST  = 1;
    localparam int ST_D2SET  = D1_FIRST + D1_QW;
    localparam int D2_FIRST  = ST_D2SET + 1;
    localparam int ST_VPB    = D2_FIRST + D2_QW;
    localparam int ST_TV     = ST_VPB + 1;
    localparam int ST_D      = ST_TV + 1;
    localparam int ST_D3     = ST_D + 1;
    localparam int ST_PROD   = ST_D3 + 1;
    localparam int ST_D3SET  = ST_PROD + 1;
    localparam int D3_FIRST  = ST_D3SET + 1;
    localparam int ST_FLR    = D3_FIRST + D3_QW;
    localparam int ST_CELLS  = ST_FLR + 1;
    localparam int ST_TOT    = ST_CELLS + 1;
    localparam int ST_MUL    = ST_TOT + 1;
    localparam int ST_CKPRE  = ST_MUL + 1;
    localparam int ST_HFL    = ST_CKPRE + 1;   // also clock partial products
    localparam int ST_HRN    = ST_HFL + 1;     // also clock product sum
    localparam int ST_HOUT   = ST_HRN + 1;
    localparam int ST_CLK    = ST_HOUT + 1;
    localparam int NST       = ST_CLK + 1;

    typedef struct packed {
        logic [13:0] active_width;
        logic [13:0] active_lines;
        logic [9:0]  refresh_hz;
    } t_req;

    typedef struct packed {
        logic        valid_res;
        logic [25:0] pixel_clock_khz;
        logic [13:0] h_active;
        logic [13:0] h_sync_begin;
        logic [13:0] h_sync_finish;
        logic [13:0] h_total;
        logic [13:0] v_active;
        logic [13:0] v_sync_begin;
        logic [13:0] v_sync_finish;
        logic [13:0] v_total;
        logic [9:0]  v_refresh;
    } t_res;

    // Working registers of one restoring division step
    typedef struct packed {
        logic [51:0] rem;
        logic [51:0] dvd;
        logic [51:0] quo;
        logic [51:0] dsr;
    } t_div;

    // Everything one item carries down the pipeline
    typedef struct packed {
        t_div               div;
        logic               ok;
        logic [9:0]         f;
        logic [13:0]        v;
        logic [14:0]        h;
        logic [14:0]        vpb;
        logic [15:0]        tv;
        logic [25:0]        d;
        logic signed [28:0] d3;
        logic [32:0]        den3;
        logic signed [44:0] prod;
        logic               neg;
        logic signed [12:0] cq;
        logic [32:0]        cr;
        logic signed [12:0] cells;
        logic signed [17:0] tot;
        logic               tneg;
        logic [14:0]        tmag;
        logic [8:0]         hq;
        logic [6:0]         hr;
        logic signed [10:0] hf;
        logic [6:0]         hfr;
        logic signed [10:0] hsq;
        logic [40:0]        px;
        logic [35:0]        cy;
        logic [53:0]        ppl;
        logic [53:0]        pph;
        logic [22:0]        mhz;
        t_res               res;
    } t_pl;

    // One quotient bit: shift in the next dividend bit, subtract if it fits
    function automatic t_div div_step(input t_div d);
        t_div       n;
        logic [52:0] t;
        n = d;
        t = {d.rem, d.dvd[51]};
        n.dvd = d.dvd << 1;
        if (t >= {1'b0, d.dsr}) begin
            n.rem = 52'(t - {1'b0, d.dsr});
            n.quo = {d.quo[50:0], 1'b1};
        end else begin
            n.rem = t[51:0];
            n.quo = {d.quo[50:0], 1'b0};
        end
        return n;
    endfunction

    // Saturate a signed value to [0, MAX14]
    function automatic logic [13:0] clamp14(input logic signed [17:0] x);
        logic [13:0] y;
        priority if (x < 0) begin
            y = '0;
        end else if (x > 18'sd16383) begin
            y = MAX14;
        end else begin
            y = x[13:0];
        end
        return y;
    endfunction

endpackage

[rtl/gtf_ifs.sv]
// Valid/ready channel interfaces for requests and timing results.
interface gtf_req_if import gtf_pkg::*; ();
    logic valid;
    logic ready;
    t_req data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface gtf_res_if import gtf_pkg::*; ();
    logic valid;
    logic ready;
    t_res data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

[rtl/gtf_display_timing_generator_core.sv]
// GTF timing generator. Throughput one request per cycle unless the output stalls;
// the three variable divisions are unrolled into one restoring-division stage per
// quotient bit, which sets the pipeline depth; the pixel clock divide by 10^6 is a
// shift and a two-stage reciprocal multiply.
// A stall at the output freezes the whole pipeline; nothing is dropped.
// Synchronous active-low reset clears all stage valid bits; data is not reset.
module gtf_display_timing_generator_core import gtf_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gtf_req_if.sink       i_req,
    gtf_res_if.source     o_res
);

    logic [NST-1:0] r_vld;
    t_pl            r_pl [NST];
    t_pl            n_pl [NST];
    logic           w_adv;

    // Pipeline moves whenever the last stage is empty or being taken
    assign w_adv       = !r_vld[NST-1] || o_res.ready;
    assign i_req.ready = w_adv;
    assign o_res.valid = r_vld[NST-1];
    assign o_res.data  = r_pl[NST-1].res;

    // Stage logic
    always_comb begin
        t_pl          p;
        logic [10:0]  wq;
        logic         up;
        logic [19:0]  num;
        logic [52:0]  t53;
        logic [44:0]  mag;
        logic [41:0]  x42;
        logic [71:0]  s72;
        logic [32:0]  k33;
        logic [14:0]  v15;
        logic signed [17:0] c8;
        logic signed [17:0] hs;
        logic signed [17:0] h18;
        p   = '0;
        wq  = '0;
        up  = 1'b0;
        num = '0;
        t53 = '0;
        mag = '0;
        x42 = '0;
        s72 = '0;
        k33 = '0;
        v15 = '0;
        c8  = '0;
        hs  = '0;
        h18 = '0;
        for (int s = 0; s < NST; s++) begin
            if (s == ST_IN) begin
                p    = '0;
                p.f  = i_req.data.refresh_hz;
                p.v  = i_req.data.active_lines;
                p.ok = (i_req.data.refresh_hz != '0);
                // width to 8-pixel cells, ties to even
                wq   = i_req.data.active_width[13:3];
                up   = (i_req.data.active_width[2:0] > 3'd4)
                    || (i_req.data.active_width[2:0] == 3'd4 && wq[0]);
                p.h  = {12'(wq) + 12'(up), 3'b000};
                // line period estimate division setup
                num  = 20'(US_PER_S) - 20'(20'(i_req.data.refresh_hz) * 20'(MIN_VBP_US));
                p.div.rem = '0;
                p.div.quo = '0;
                p.div.dvd = 52'(num) << FRAC_BITS;
                p.div.dsr = 52'(24'(i_req.data.refresh_hz)
                          * (24'(i_req.data.active_lines) + 24'd1));
            end else begin
                p = r_pl[s-1];
            end

            // restoring division steps
            if ((s >= D1_FIRST && s < D1_FIRST + D1_QW)
                || (s >= D2_FIRST && s < D2_FIRST + D2_QW)
                || (s >= D3_FIRST && s < D3_FIRST + D3_QW)) begin
                p.div = div_step(p.div);
            end

            // vsync+bp: 550 us over the line period estimate
            if (s == ST_D2SET) begin
                p.div.dsr = p.div.quo;
                p.div.rem = 52'(MIN_VBP_US) << (FRAC_BITS - D2_QW);
                p.div.dvd = '0;
                p.div.quo = '0;
            end

            if (s == ST_VPB) begin
                t53   = {p.div.rem, 1'b0};
                up    = (t53 > {1'b0, p.div.dsr})
                     || (t53 == {1'b0, p.div.dsr} && p.div.quo[0]);
                p.vpb = p.div.quo[14:0] + 15'(up);
            end

            if (s == ST_TV) begin
                p.tv = 16'(p.v) + 16'(p.vpb) + 16'd1;
            end

            if (s == ST_D) begin
                p.d = 26'(26'(p.f) * 26'(p.tv));
            end

            // duty cycle numerator and denominator terms
            if (s == ST_D3) begin
                p.d3   = $signed(29'(29'(p.d) * 29'd3) - 29'd30000);
                p.den3 = 33'((33'(p.d) * 33'd7 + 33'd30000) << 4);
            end

            if (s == ST_PROD) begin
                p.prod = $signed({1'b0, p.h}) * p.d3;
            end

            // magnitude division setup for blanking cells
            if (s == ST_D3SET) begin
                p.neg     = p.prod[44];
                mag       = p.neg ? 45'(-p.prod) : 45'(p.prod);
                p.div.rem = 52'(mag >> D3_QW);
                p.div.dvd = {mag[D3_QW-1:0], 41'b0};
                p.div.dsr = 52'(p.den3);
                p.div.quo = '0;
            end

            // signed floor from magnitude quotient
            if (s == ST_FLR) begin
                if (p.neg && p.div.rem[32:0] != '0) begin
                    p.cq = -$signed({2'b00, p.div.quo[10:0]}) - 13'sd1;
                    p.cr = p.den3 - p.div.rem[32:0];
                end else if (p.neg) begin
                    p.cq = -$signed({2'b00, p.div.quo[10:0]});
                    p.cr = '0;
                end else begin
                    p.cq = $signed({2'b00, p.div.quo[10:0]});
                    p.cr = p.div.rem[32:0];
                end
            end

            if (s == ST_CELLS) begin
                up      = ({p.cr, 1'b0} > {1'b0, p.den3})
                       || ({p.cr, 1'b0} == {1'b0, p.den3} && p.cq[0]);
                p.cells = p.cq + $signed({12'b0, up});
            end

            if (s == ST_TOT) begin
                p.tot = $signed({3'b000, p.h}) + (18'(p.cells) <<< 4);
            end

            // hsync /100 by reciprocal, clock numerator product
            if (s == ST_MUL) begin
                p.tneg = p.tot[17];
                p.tmag = p.tneg ? 15'(-p.tot) : 15'(p.tot);
                p.hq   = 9'((32'(p.tmag) * 32'(RCP100)) >> RCP100_SH);
                p.px   = 41'(p.tmag) * 41'(p.d);
            end

            // hsync remainder; clock numerator rounded up, then /64
            if (s == ST_CKPRE) begin
                p.hr = 7'(p.tmag - 15'(15'(p.hq) * 15'd100));
                x42  = 42'(p.px) + 42'(US_PER_S - 1);
                p.cy = 36'(x42 >> CLK_PRE_SH);
            end

            if (s == ST_HFL) begin
                if (p.tneg && p.hr != '0) begin
                    p.hf  = -$signed({2'b00, p.hq}) - 11'sd1;
                    p.hfr = 7'd100 - p.hr;
                end else if (p.tneg) begin
                    p.hf  = -$signed({2'b00, p.hq});
                    p.hfr = '0;
                end else begin
                    p.hf  = $signed({2'b00, p.hq});
                    p.hfr = p.hr;
                end
                // /15625 by reciprocal: two half-width partial products
                p.ppl = 54'(p.cy[17:0]) * 54'(RCP15625);
                p.pph = 54'(p.cy[35:18]) * 54'(RCP15625);
            end

            if (s == ST_HRN) begin
                up    = ({p.hfr, 1'b0} > 8'd100) || ({p.hfr, 1'b0} == 8'd100 && p.hf[0]);
                p.hsq = p.hf + $signed({10'b0, up});
                s72   = {p.pph, 18'b0} + 72'(p.ppl);
                p.mhz = 23'(s72 >> RCP15625_SH);
            end

            // horizontal result fields
            if (s == ST_HOUT) begin
                c8  = 18'(p.cells) <<< 3;
                hs  = 18'(p.hsq) <<< 3;
                h18 = $signed({3'b000, p.h});
                p.res.h_active      = clamp14(h18);
                p.res.h_sync_begin  = clamp14(h18 + c8 - hs);
                p.res.h_sync_finish = clamp14(h18 + c8);
                p.res.h_total       = clamp14(p.tot);
            end

            // pixel clock and vertical fields; zero result when invalid
            if (s == ST_CLK) begin
                k33 = 33'(p.mhz) * 33'd1000;
                if (p.tneg || p.tmag == '0) begin
                    p.res.pixel_clock_khz = '0;
                end else if (k33 > 33'(MAX26)) begin
                    p.res.pixel_clock_khz = MAX26;
                end else begin
                    p.res.pixel_clock_khz = k33[25:0];
                end
                p.res.valid_res     = 1'b1;
                p.res.v_active      = p.v;
                v15                 = 15'(p.v) + 15'd1;
                p.res.v_sync_begin  = v15[14] ? MAX14 : v15[13:0];
                v15                 = 15'(p.v) + 15'd4;
                p.res.v_sync_finish = v15[14] ? MAX14 : v15[13:0];
                p.res.v_total       = (p.tv > 16'(MAX14)) ? MAX14 : p.tv[13:0];
                p.res.v_refresh     = p.f;
                if (!p.ok) begin
                    p.res = '0;
                end
            end

            n_pl[s] = p;
        end
    end

    // Stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= {r_vld[NST-2:0], i_req.valid};
        end
    end

    // Stage data
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_pl <= n_pl;
        end
    end

endmodule

[rtl/gtf_chk.sv]
// Port-level checks of the GTF timing generator, bound to the top level.
module gtf_chk import gtf_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_rdy,
    input logic i_out_vld,
    input logic i_out_rdy,
    input t_res i_out
);

    // Held result beat stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out_rdy |=> i_out_vld && $stable(i_out))
        else $error("result beat changed while stalled");

    // Input is taken exactly when the pipeline can move
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_rdy == (!i_out_vld || i_out_rdy))
        else $error("request ready does not follow output backpressure");

    // Reset empties the pipeline
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_vld)
        else $error("result valid after reset");

    // Result with valid_res low has zero pixel clock, totals and refresh
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && !i_out.valid_res |-> i_out.pixel_clock_khz == '0
            && i_out.h_total == '0 && i_out.v_total == '0 && i_out.v_refresh == '0)
        else $error("invalid result carries timings");

    // Vertical ordering and cell-aligned width
    a_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_vld && i_out.valid_res |-> i_out.v_sync_finish >= i_out.v_sync_begin
            && i_out.v_sync_begin >= i_out.v_active
            && (i_out.h_active[2:0] == 3'd0 || i_out.h_active == MAX14))
        else $error("timing fields out of order");

endmodule

bind gtf_display_timing_generator_core gtf_chk u_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_in_rdy  (i_req.ready),
    .i_out_vld (o_res.valid),
    .i_out_rdy (o_res.ready),
    .i_out     (o_res.data)
);

[tb/sv/gtf_display_timing_generator_core_tb.sv]
// Self-checking testbench for the GTF display timing generator core.
module gtf_display_timing_generator_core_tb;
    import gtf_pkg::*;

    localparam int LATENCY   = 95;
    localparam int N_RANDOM  = 1500;
    localparam int CYCLE_LIM = 400000;
    localparam int CELL      = 8;

    logic i_clk = 1'b0;
    logic i_rst_n;

    gtf_req_if req_ch();
    gtf_res_if res_ch();

    gtf_display_timing_generator_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    // Clock: period 2
    always begin
        #1;
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
    end

    t_res timing_q[$];
    int   n_mismatch = 0;
    int   n_cycles = 0;

    // Round to nearest, ties to even, b > 0
    function automatic longint rne_div(input longint a, input longint b);
        longint q;
        longint r;
        q = a / b;
        r = a % b;
        if (r < 0) begin
            q = q - 1;
            r = r + b;
        end
        if (2 * r > b || (2 * r == b && q[0]))
            q = q + 1;
        return q;
    endfunction

    function automatic longint sat(input longint x, input longint hi);
        if (x < 0)
            return 0;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // Predict GTF timings for one request
    function automatic t_res gtf_timing(input t_req r);
        t_res   o;
        longint w, v, f, num, h, vpb, tv, d, cells, tot, hs, hfp, mhz;
        longint unsigned hpe;
        w = r.active_width;
        v = r.active_lines;
        f = r.refresh_hz;
        o = '0;
        num = 64'(US_PER_S) - 64'(MIN_VBP_US) * f;
        if (f == 0 || num <= 0)
            return o;
        hpe = (longint'(num) << FRAC_BITS) / longint'(f * (v + 1));
        if (hpe == 0)
            return o;
        h = rne_div(w, CELL) * CELL;
        vpb = rne_div(longint'(MIN_VBP_US) << FRAC_BITS, longint'(hpe));
        tv = v + vpb + 1;
        d = f * tv;
        cells = rne_div(h * (3 * d - 30000), 2 * CELL * (7 * d + 30000));
        tot = h + cells * 2 * CELL;
        hs = rne_div(8 * tot, 100 * CELL) * CELL;
        hfp = cells * CELL - hs;
        o.valid_res = 1'b1;
        if (tot > 0) begin
            mhz = (tot * d + (US_PER_S - 1)) / US_PER_S;
            o.pixel_clock_khz = 26'(sat(mhz * 1000, 67108863));
        end
        o.h_active      = 14'(sat(h, 16383));
        o.h_sync_begin  = 14'(sat(h + hfp, 16383));
        o.h_sync_finish = 14'(sat(h + hfp + hs, 16383));
        o.h_total       = 14'(sat(tot, 16383));
        o.v_active      = 14'(sat(v, 16383));
        o.v_sync_begin  = 14'(sat(v + 1, 16383));
        o.v_sync_finish = 14'(sat(v + 4, 16383));
        o.v_total       = 14'(sat(tv, 16383));
        o.v_refresh     = 10'(sat(f, 1023));
        return o;
    endfunction

    // Directed table: request, typed expectation where obvious
    typedef struct {
        t_req r;
        bit   has_exp;
        t_res e;
    } t_row;

    t_row dir_tab[$];

    function automatic t_req mk(input int w, input int v, input int f);
        t_req r;
        r.active_width = 14'(w);
        r.active_lines = 14'(v);
        r.refresh_hz   = 10'(f);
        return r;
    endfunction

    task automatic add_row(input t_req r, input bit typed);
        t_row row;
        row.r = r;
        row.has_exp = typed;
        row.e = '0;
        dir_tab.push_back(row);
    endtask

    function automatic t_req rand_req();
        t_req r;
        int   k;
        k = $urandom_range(0, 9);
        r.active_width = 14'($urandom);
        r.active_lines = 14'($urandom);
        r.refresh_hz   = 10'($urandom);
        if (k < 7) begin
            // typical modes
            r.active_width = 14'($urandom_range(8, 8192));
            r.active_lines = 14'($urandom_range(1, 8192));
            r.refresh_hz   = 10'($urandom_range(1, 200));
        end else if (k == 7) begin
            r.refresh_hz = 10'($urandom_range(1700, 1823) & 10'h3FF);
        end
        return r;
    endfunction

    t_req stim_q[$];

    // Sender: bursts with gaps, at least one full drain pause midway
    initial begin
        int burst;
        int idx;
        t_row row;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        i_rst_n = 1'b0;
        // zero rate extremes (forced invalid: typed)
        row.r = mk(8, 1, 0); row.has_exp = 1; row.e = '0; dir_tab.push_back(row);
        row.r = mk(16383, 16383, 0); dir_tab.push_back(row);
        add_row(mk(640, 480, 1023), 0);
        add_row(mk(640, 480, 1819), 0);
        add_row(mk(640, 480, 60), 0);
        add_row(mk(800, 600, 72), 0);
        add_row(mk(1920, 1080, 60), 0);
        add_row(mk(8, 1, 1), 0);
        add_row(mk(8192, 8192, 1), 0);
        add_row(mk(8192, 8192, 200), 0);
        add_row(mk(16383, 16383, 1), 0);
        add_row(mk(12, 100, 60), 0);
        add_row(mk(20, 100, 60), 0);
        add_row(mk(4, 1, 30), 0);
        add_row(mk(0, 0, 1), 0);
        add_row(mk(1024, 768, 1818), 0);
        add_row(mk(1024, 768, 1817 & 1023), 0);
        add_row(mk(3840, 2160, 120), 0);
        add_row(mk(8192, 16383, 1000), 0);
        add_row(mk(16383, 1, 999), 0);
        add_row(mk(16383, 16383, 1023), 0);
        add_row(mk(100, 50, 5), 0);
        for (int i = 0; i < N_RANDOM; i++)
            stim_q.push_back(rand_req());
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;
        foreach (dir_tab[i])
            stim_q.push_front(dir_tab[dir_tab.size() - 1 - i].r);
        idx = 0;
        while (stim_q.size() > 0) begin
            burst = $urandom_range(1, 40);
            while (burst > 0 && stim_q.size() > 0) begin
                @(negedge i_clk);
                req_ch.valid = 1'b1;
                req_ch.data  = stim_q[0];
                @(posedge i_clk);
                while (!req_ch.ready)
                    @(posedge i_clk);
                if (idx < dir_tab.size() && dir_tab[idx].has_exp)
                    timing_q.push_back(dir_tab[idx].e);
                else
                    timing_q.push_back(gtf_timing(stim_q[0]));
                void'(stim_q.pop_front());
                idx++;
                burst--;
            end
            @(negedge i_clk);
            req_ch.valid = 1'b0;
            if (idx > 600 && idx <= 640) begin
                while (timing_q.size() > 0)
                    @(negedge i_clk);
            end
            repeat ($urandom_range(0, 6) * ($urandom_range(0, 2) != 0))
                @(negedge i_clk);
        end
        while (timing_q.size() > 0)
            @(negedge i_clk);
        repeat (LATENCY + 20) @(negedge i_clk);
        if (n_mismatch == 0)
            $display("gtf_display_timing_generator_core_tb OK");
        else
            $display("gtf_display_timing_generator_core_tb NOT OK");
        $finish;
    end

    // Receiver stall pattern
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (n_cycles % 3000 < 800)
                res_ch.ready = 1'b1;
            else
                res_ch.ready = ($urandom_range(0, 3) != 0);
        end
    end

    // Result checking and timeout
    always @(posedge i_clk) begin
        t_res exp_r;
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIM) begin
            $display("gtf_display_timing_generator_core_tb NOT OK");
            $finish;
        end
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (timing_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10)
                    $display("unexpected result beat %p", res_ch.data);
            end else begin
                exp_r = timing_q.pop_front();
                if (res_ch.data !== exp_r) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: exp %p got %p", exp_r, res_ch.data);
                end
            end
        end
    end

endmodule
